>>> hdl/aatu_pkg.sv
// Package for the box transform unit: widths, fixed-point types, register map
// and reset values. Used by every file under hdl; depends on nothing.
package aatu_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int NUM_AXES    = 3;

  // Full product, product after the fraction shift, and the row sum.
  // The shifted product is at most 2^46 in magnitude, so a row sum of three
  // such products and the translation always fits in SUM_WIDTH bits.
  localparam int MUL_WIDTH  = COORD_WIDTH + ENTRY_WIDTH;
  localparam int PROD_WIDTH = MUL_WIDTH - FRAC_BITS;
  localparam int SUM_WIDTH  = PROD_WIDTH + 2;

  // Register file: six 64-bit registers at byte address 8*i.
  localparam int REG_WIDTH  = 2 * ENTRY_WIDTH;
  localparam int NUM_REGS   = 6;
  localparam int IDX_WIDTH  = 3;
  localparam int ADDR_LSB   = 3;
  localparam int ADDR_WIDTH = IDX_WIDTH + ADDR_LSB;

  localparam int REG_M00_M01 = 0;
  localparam int REG_M02_M03 = 1;
  localparam int REG_M10_M11 = 2;
  localparam int REG_M12_M13 = 3;
  localparam int REG_M20_M21 = 4;
  localparam int REG_M22_M23 = 5;

  localparam logic [REG_WIDTH-1:0] ONE_FIX = REG_WIDTH'(1) << FRAC_BITS;
  localparam logic [REG_WIDTH-1:0] ONE_FIX_HIGH = ONE_FIX << ENTRY_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  // One matrix row; m3 is the translation.
  typedef struct packed {
    entry_t m3;
    entry_t m2;
    entry_t m1;
    entry_t m0;
  } row_t;

  // Per-column smaller and larger product found by one lane.
  typedef struct packed {
    prod_t [NUM_AXES-1:0] lo;
    prod_t [NUM_AXES-1:0] hi;
  } lane_t;

  localparam sum_t SUM_COORD_MAX =
    {{(SUM_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam sum_t SUM_COORD_MIN = ~SUM_COORD_MAX;

endpackage

>>> hdl/aatu_if.sv
// Handshake channels of the box transform unit: input box and result box.
// Depends on aatu_pkg for the coordinate width.
interface aatu_in_if;
  logic valid;
  logic ready;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] min_x;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] min_y;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] min_z;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] max_x;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] max_y;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface aatu_out_if;
  logic valid;
  logic ready;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] out_min_x;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] out_min_y;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] out_min_z;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] out_max_x;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] out_max_y;
  logic signed [aatu_pkg::COORD_WIDTH-1:0] out_max_z;

  modport source (output valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, input ready);
  modport sink   (input valid, out_min_x, out_min_y, out_min_z,
                  out_max_x, out_max_y, out_max_z, output ready);
endinterface

>>> hdl/aatu_lane.sv
// One lane of the box transform unit: the products of one matrix row with
// both box extents, then the smaller and larger product per column.
// Depends on aatu_pkg.
module aatu_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  aatu_pkg::row_t                       row,
  input  aatu_pkg::coord_t [aatu_pkg::NUM_AXES-1:0] bmin,
  input  aatu_pkg::coord_t [aatu_pkg::NUM_AXES-1:0] bmax,
  output aatu_pkg::lane_t                      result
);
  import aatu_pkg::*;

  entry_t                       coef    [NUM_AXES];
  logic signed [MUL_WIDTH-1:0]  mul_lo  [NUM_AXES];
  logic signed [MUL_WIDTH-1:0]  mul_hi  [NUM_AXES];
  prod_t                        prod_lo [NUM_AXES];
  prod_t                        prod_hi [NUM_AXES];

  assign coef[0] = row.m0;
  assign coef[1] = row.m1;
  assign coef[2] = row.m2;

  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      mul_lo[c] = MUL_WIDTH'(coef[c]) * MUL_WIDTH'(bmin[c]);
      mul_hi[c] = MUL_WIDTH'(coef[c]) * MUL_WIDTH'(bmax[c]);
    end
  end

  // Dropping the low fraction bits is the arithmetic shift toward minus infinity.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        prod_lo[c] <= mul_lo[c][MUL_WIDTH-1:FRAC_BITS];
        prod_hi[c] <= mul_hi[c][MUL_WIDTH-1:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_AXES; c++) begin
        if (prod_lo[c] < prod_hi[c]) begin
          result.lo[c] <= prod_lo[c];
          result.hi[c] <= prod_hi[c];
        end else begin
          result.lo[c] <= prod_hi[c];
          result.hi[c] <= prod_lo[c];
        end
      end
    end
  end

endmodule

>>> hdl/aatu_merge.sv
// Merging stage of the box transform unit: adds the translation to the
// lane extremes, saturates and holds the result box. Depends on aatu_pkg.
module aatu_merge (
  input  logic             clk,
  input  logic             en,
  input  aatu_pkg::lane_t  lanes  [aatu_pkg::NUM_AXES],
  input  aatu_pkg::entry_t trans  [aatu_pkg::NUM_AXES],
  output aatu_pkg::coord_t box_lo [aatu_pkg::NUM_AXES],
  output aatu_pkg::coord_t box_hi [aatu_pkg::NUM_AXES]
);
  import aatu_pkg::*;

  sum_t sum_lo [NUM_AXES];
  sum_t sum_hi [NUM_AXES];

  function automatic coord_t saturate(input sum_t s);
    coord_t r;
    if (s > SUM_COORD_MAX) begin
      r = SUM_COORD_MAX[COORD_WIDTH-1:0];
    end else if (s < SUM_COORD_MIN) begin
      r = SUM_COORD_MIN[COORD_WIDTH-1:0];
    end else begin
      r = s[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sum_lo[k] = SUM_WIDTH'(trans[k]);
      sum_hi[k] = SUM_WIDTH'(trans[k]);
      for (int c = 0; c < NUM_AXES; c++) begin
        sum_lo[k] = sum_lo[k] + SUM_WIDTH'($signed(lanes[k].lo[c]));
        sum_hi[k] = sum_hi[k] + SUM_WIDTH'($signed(lanes[k].hi[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        box_lo[k] <= saturate(sum_lo[k]);
        box_hi[k] <= saturate(sum_hi[k]);
      end
    end
  end

endmodule

>>> hdl/aabb_affine_transform_unit.sv
// Box transform unit, top level: register file, three row lanes, merging stage.
// An accepted input beat passes the product, selection and output registers.
// Throughput: one box per cycle unless stalled; set by 18 32x32 multipliers.
// Reset (rst, synchronous): empties the pipeline and loads the identity matrix.
// Depends on aatu_pkg, aatu_if, aatu_lane and aatu_merge.
module aabb_affine_transform_unit (
  input  logic                               clk,
  input  logic                               rst,
  aatu_in_if.sink                            in_box,
  aatu_out_if.source                         out_box,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [aatu_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [aatu_pkg::REG_WIDTH-1:0]     pwdata,
  output logic [aatu_pkg::REG_WIDTH-1:0]     prdata,
  output logic                               pready
);
  import aatu_pkg::*;

  // Each transformed coordinate is t + f0(p0) + f1(p1) + f2(p2), where every
  // term depends on one input coordinate only, and saturation is monotone.
  // So the least of the eight corners is the translation plus the smaller
  // product of every column, saturated, and likewise for the greatest.
  // Each lane handles one matrix row (one output axis) and finds those
  // per-column extremes; the merging stage sums and saturates them.

  logic [REG_WIDTH-1:0] cfg_regs [NUM_REGS];
  logic [IDX_WIDTH-1:0] reg_idx;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_WIDTH-1:ADDR_LSB];
  assign cfg_write = psel && penable && pwrite;

  // Writes beyond the last register are dropped and such reads return zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs[REG_M00_M01] <= ONE_FIX;
      cfg_regs[REG_M02_M03] <= '0;
      cfg_regs[REG_M10_M11] <= ONE_FIX_HIGH;
      cfg_regs[REG_M12_M13] <= '0;
      cfg_regs[REG_M20_M21] <= '0;
      cfg_regs[REG_M22_M23] <= ONE_FIX;
    end else if (cfg_write && (reg_idx < IDX_WIDTH'(NUM_REGS))) begin
      cfg_regs[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    if (reg_idx < IDX_WIDTH'(NUM_REGS)) begin
      prdata = cfg_regs[reg_idx];
    end else begin
      prdata = '0;
    end
  end

  // The user must ensure the matrix only changes while idle; nothing checks it.
  row_t   rows  [NUM_AXES];
  entry_t trans [NUM_AXES];

  assign rows[0] = {cfg_regs[REG_M02_M03], cfg_regs[REG_M00_M01]};
  assign rows[1] = {cfg_regs[REG_M12_M13], cfg_regs[REG_M10_M11]};
  assign rows[2] = {cfg_regs[REG_M22_M23], cfg_regs[REG_M20_M21]};

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      trans[k] = rows[k].m3;
    end
  end

  // Pipeline control. All three stages move together; the last stage is the
  // output register, so a new beat is taken whenever that register is empty
  // or its beat leaves in the same cycle.
  logic en;
  logic v_prod;
  logic v_sel;
  logic v_out;

  assign en           = !v_out || out_box.ready;
  assign in_box.ready = en;
  assign out_box.valid = v_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod <= 1'b0;
      v_sel  <= 1'b0;
      v_out  <= 1'b0;
    end else if (en) begin
      v_prod <= in_box.valid;
      v_sel  <= v_prod;
      v_out  <= v_sel;
    end
  end

  coord_t [NUM_AXES-1:0] bmin;
  coord_t [NUM_AXES-1:0] bmax;

  assign bmin = {in_box.min_z, in_box.min_y, in_box.min_x};
  assign bmax = {in_box.max_z, in_box.max_y, in_box.max_x};

  lane_t lanes [NUM_AXES];

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    aatu_lane u_lane (
      .clk    (clk),
      .en     (en),
      .row    (rows[k]),
      .bmin   (bmin),
      .bmax   (bmax),
      .result (lanes[k])
    );
  end

  coord_t box_lo [NUM_AXES];
  coord_t box_hi [NUM_AXES];

  aatu_merge u_merge (
    .clk    (clk),
    .en     (en),
    .lanes  (lanes),
    .trans  (trans),
    .box_lo (box_lo),
    .box_hi (box_hi)
  );

  assign out_box.out_min_x = box_lo[0];
  assign out_box.out_min_y = box_lo[1];
  assign out_box.out_min_z = box_lo[2];
  assign out_box.out_max_x = box_hi[0];
  assign out_box.out_max_y = box_hi[1];
  assign out_box.out_max_z = box_hi[2];

endmodule

>>> hdl/aatu_checker.sv
// Port-level checks for the box transform unit, bound to the top level.
// Depends on aatu_pkg and on the ports of aabb_affine_transform_unit.
module aatu_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     in_valid,
  input logic                                     in_ready,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic [6*aatu_pkg::COORD_WIDTH-1:0]       out_data
);
  import aatu_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

  // The input side never stalls while the output side drains.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled with a free output register");

  // An accepted box shows up as a result beat when the output is not blocked.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result beat missing after three cycles");

endmodule

bind aabb_affine_transform_unit aatu_checker u_aatu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_box.valid),
  .in_ready  (in_box.ready),
  .out_valid (out_box.valid),
  .out_ready (out_box.ready),
  .out_data  ({out_box.out_min_x, out_box.out_min_y, out_box.out_min_z,
               out_box.out_max_x, out_box.out_max_y, out_box.out_max_z})
);
